@@ hdl/sbra_pkg.sv @@
// ----------------------------------------------------------------------------
// sbra_pkg
// Shared types and constants of the slot bitmap region allocator.
// ----------------------------------------------------------------------------
package sbra_pkg;

    localparam int SLOT_IDX_W = 5;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_SHRINK  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

    localparam logic       REG_BUFFER_BASE = 1'b0;
    localparam logic       REG_BUFFER_SIZE = 1'b1;

    localparam logic [16:0] ALIGN_LOW  = 17'h00007;
    localparam logic [15:0] SIZE_RESET = 16'd2000;
    localparam logic [5:0]  NO_SLOT    = 6'd63;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FIND,
        S_COLLAPSE,
        S_SHRINK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  clear_all;
        logic                  wr_start;
        logic                  wr_len;
        logic                  trim;
        logic [SLOT_IDX_W-1:0] wr_idx;
        logic [SLOT_IDX_W-1:0] trim_idx;
        logic [15:0]           start;
        logic [15:0]           len;
    } t_tbl_ctl;

    function automatic logic [16:0] round8(input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + ALIGN_LOW;
        return s & ~ALIGN_LOW;
    endfunction

endpackage

@@ hdl/sbra_slot_table.sv @@
// ----------------------------------------------------------------------------
// sbra_slot_table
// Per-slot start offset and length, one read port, tail trim and full clear.
// ----------------------------------------------------------------------------
module sbra_slot_table #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sbra_pkg::t_tbl_ctl                  i_ctl,
    input  logic [sbra_pkg::SLOT_IDX_W-1:0]     i_rd_idx,
    output logic [15:0]                         o_rd_start,
    output logic [15:0]                         o_rd_len
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [15:0] r_start [SLOT_COUNT];
    logic [15:0] r_len   [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear_all) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_start[k] <= '0;
                r_len[k]   <= '0;
            end
        end else begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (i_ctl.trim && (sbra_pkg::SLOT_IDX_W'(k) >= i_ctl.trim_idx)) begin
                    r_start[k] <= '0;
                    r_len[k]   <= '0;
                end else begin
                    if (i_ctl.wr_start && (i_ctl.wr_idx[IW-1:0] == IW'(k))) begin
                        r_start[k] <= i_ctl.start;
                    end
                    if (i_ctl.wr_len && (i_ctl.wr_idx[IW-1:0] == IW'(k))) begin
                        r_len[k] <= i_ctl.len;
                    end
                end
            end
        end
    end

    assign o_rd_start = r_start[i_rd_idx[IW-1:0]];
    assign o_rd_len   = r_len[i_rd_idx[IW-1:0]];

endmodule

@@ hdl/slot_bitmap_region_allocator.sv @@
// ----------------------------------------------------------------------------
// slot_bitmap_region_allocator
// Allocate, release and shrink blocks of one buffer with a used-slot bitmap.
// ----------------------------------------------------------------------------
// sequence: unknown commands and rejected sizes pass the setup and output states,
// shrink passes setup, shrink and output; allocate and release pass setup, scan
// (one slot per scan cycle) and output; a release of the top used slot adds the
// find and collapse states; output waits while an untaken result is held
// throughput: one item at a time, the next is accepted once the result is
// loaded into the output register
// reset: slots and bitmap cleared, buffer_base 0, buffer_size 2000
module slot_bitmap_region_allocator #(
    parameter int SLOT_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // command[1:0], req_size[18:2], address[50:19]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status[1:0], block_address[33:2],
                                        // block_size[49:34], slot[54:50]
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    sbra_pkg::t_state r_state, n_state;
    logic [1:0]              r_cmd, n_cmd;
    logic signed [16:0]      r_req, n_req;
    logic [31:0]             r_addr, n_addr;
    logic [16:0]             r_size, n_size;
    logic [15:0]             r_avail, n_avail;
    logic [31:0]             r_off, n_off;
    logic [IW-1:0]           r_ix, n_ix;
    logic [IW-1:0]           r_p, n_p;
    logic [SLOT_COUNT-1:0]   r_mask, n_mask;
    logic [SLOT_COUNT-1:0]   r_used, n_used;
    logic [15:0]             r_free, n_free;
    logic [5:0]              r_lb, n_lb;
    logic [31:0]             r_base, n_base;
    logic [15:0]             r_bsize, n_bsize;
    logic [1:0]              r_res_status, n_res_status;
    logic [15:0]             r_res_start, n_res_start;
    logic [15:0]             r_res_len, n_res_len;
    logic [IW-1:0]           r_res_slot, n_res_slot;
    logic                    r_o_valid, n_o_valid;
    logic [1:0]              r_o_status, n_o_status;
    logic [31:0]             r_o_addr, n_o_addr;
    logic [15:0]             r_o_size, n_o_size;
    logic [4:0]              r_o_slot, n_o_slot;

    sbra_pkg::t_tbl_ctl      tbl_ctl;
    logic [4:0]              rd_idx;
    logic [15:0]             rd_start;
    logic [15:0]             rd_len;

    logic [15:0]             avail_c;
    logic [15:0]             base_sz;
    logic [16:0]             end_sum;
    logic                    in_blk;
    logic                    lb_live;
    logic [16:0]             sh_size;
    logic [15:0]             sh_len;
    logic                    sh_match;

    sbra_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_rd_idx   (rd_idx),
        .o_rd_start (rd_start),
        .o_rd_len   (rd_len)
    );

    assign s_axis_tready = (r_state == sbra_pkg::S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o_slot, r_o_size, r_o_addr, r_o_status};

    assign avail_c  = (r_free < r_bsize) ? (r_bsize - r_free) : 16'd0;
    assign end_sum  = {1'b0, rd_start} + {1'b0, rd_len};
    assign in_blk   = (r_off[31:17] == '0) && (r_off[16:0] >= {1'b0, rd_start})
                      && (r_off[16:0] < end_sum);
    assign lb_live  = (r_lb < 6'(SLOT_COUNT)) && r_used[r_lb[IW-1:0]];
    assign sh_match = ((r_base + {16'd0, rd_start}) == r_addr);
    assign sh_size  = r_req[16] ? 17'd0 : sbra_pkg::round8(r_req[15:0]);
    assign sh_len   = (sh_size > {1'b0, rd_len}) ? rd_len : sh_size[15:0];

    always_comb begin
        case (r_req)
            17'sd0:  base_sz = avail_c;
            -17'sd1: base_sz = avail_c >> 1;
            default: base_sz = r_req[15:0];
        endcase
    end

    always_comb begin
        case (r_state)
            sbra_pkg::S_SHRINK:   rd_idx = r_lb[4:0];
            sbra_pkg::S_COLLAPSE: rd_idx = 5'(r_p);
            default:              rd_idx = 5'(r_ix);
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_addr       = r_addr;
        n_size       = r_size;
        n_avail      = r_avail;
        n_off        = r_off;
        n_ix         = r_ix;
        n_p          = r_p;
        n_mask       = r_mask;
        n_used       = r_used;
        n_free       = r_free;
        n_lb         = r_lb;
        n_base       = r_base;
        n_bsize      = r_bsize;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_len    = r_res_len;
        n_res_slot   = r_res_slot;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_addr     = r_o_addr;
        n_o_size     = r_o_size;
        n_o_slot     = r_o_slot;
        tbl_ctl      = '0;

        if (r_o_valid && m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            sbra_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tdata[1:0];
                    n_req   = s_axis_tdata[18:2];
                    n_addr  = s_axis_tdata[50:19];
                    n_state = sbra_pkg::S_SETUP;
                end
            end
            sbra_pkg::S_SETUP: begin
                n_ix   = '0;
                n_mask = r_used;
                n_off  = r_addr - r_base;
                case (r_cmd)
                    sbra_pkg::CMD_ALLOC: begin
                        n_avail = avail_c;
                        n_size  = sbra_pkg::round8(base_sz);
                        if (r_req[16] && (r_req != -17'sd1)) begin
                            n_res_status = sbra_pkg::STATUS_NO_SPACE;
                            n_state      = sbra_pkg::S_OUT;
                        end else begin
                            n_state = sbra_pkg::S_SCAN;
                        end
                    end
                    sbra_pkg::CMD_RELEASE: begin
                        n_state = sbra_pkg::S_SCAN;
                    end
                    sbra_pkg::CMD_SHRINK: begin
                        n_state = sbra_pkg::S_SHRINK;
                    end
                    default: begin
                        n_res_status = sbra_pkg::STATUS_NO_MATCH;
                        n_state      = sbra_pkg::S_OUT;
                    end
                endcase
            end
            sbra_pkg::S_SCAN: begin
                n_ix   = r_ix + 1'b1;
                n_mask = r_mask >> 1;
                if (r_ix == LAST) begin
                    n_res_status = (r_cmd == sbra_pkg::CMD_ALLOC) ?
                                   sbra_pkg::STATUS_NO_SPACE : sbra_pkg::STATUS_NO_MATCH;
                    n_state      = sbra_pkg::S_OUT;
                end
                n_res_slot = r_ix;
                if (r_cmd == sbra_pkg::CMD_ALLOC) begin
                    if (!r_mask[0]) begin
                        if (r_mask == '0) begin
                            n_state = sbra_pkg::S_OUT;
                            if (r_size > {1'b0, r_avail}) begin
                                n_res_status = sbra_pkg::STATUS_NO_SPACE;
                            end else begin
                                tbl_ctl.wr_start = 1'b1;
                                tbl_ctl.wr_len   = 1'b1;
                                tbl_ctl.wr_idx   = 5'(r_ix);
                                tbl_ctl.start    = r_free;
                                tbl_ctl.len      = r_size[15:0];
                                n_free           = r_free + r_size[15:0];
                                n_used           = r_used | (SLOT_COUNT'(1) << r_ix);
                                n_lb             = 6'(r_ix);
                                n_res_status     = sbra_pkg::STATUS_OK;
                                n_res_start      = r_free;
                                n_res_len        = r_size[15:0];
                            end
                        end else if ({1'b0, rd_len} == r_size) begin
                            n_used       = r_used | (SLOT_COUNT'(1) << r_ix);
                            n_res_status = sbra_pkg::STATUS_OK;
                            n_res_start  = rd_start;
                            n_res_len    = rd_len;
                            n_state      = sbra_pkg::S_OUT;
                        end
                    end
                end else if (r_mask[0] && in_blk) begin
                    n_used       = r_used & ~(SLOT_COUNT'(1) << r_ix);
                    n_res_status = sbra_pkg::STATUS_OK;
                    n_res_start  = rd_start;
                    n_res_len    = rd_len;
                    n_p          = r_ix;
                    n_state      = ((r_mask >> 1) == '0) ? sbra_pkg::S_FIND : sbra_pkg::S_OUT;
                end
            end
            sbra_pkg::S_FIND: begin
                if (r_p == '0) begin
                    n_state = sbra_pkg::S_COLLAPSE;
                end else if (r_used[IW'(r_p - 1'b1)]) begin
                    n_state = sbra_pkg::S_COLLAPSE;
                end else begin
                    n_p = r_p - 1'b1;
                end
            end
            sbra_pkg::S_COLLAPSE: begin
                n_free           = rd_start;
                tbl_ctl.trim     = 1'b1;
                tbl_ctl.trim_idx = 5'(r_p);
                n_state          = sbra_pkg::S_OUT;
            end
            sbra_pkg::S_SHRINK: begin
                n_state = sbra_pkg::S_OUT;
                if (lb_live && sh_match) begin
                    tbl_ctl.wr_len = 1'b1;
                    tbl_ctl.wr_idx = r_lb[4:0];
                    tbl_ctl.len    = sh_len;
                    n_free         = rd_start + sh_len;
                    n_res_status   = sbra_pkg::STATUS_OK;
                    n_res_start    = rd_start;
                    n_res_len      = sh_len;
                    n_res_slot     = r_lb[IW-1:0];
                end else begin
                    n_res_status = sbra_pkg::STATUS_NO_MATCH;
                end
            end
            sbra_pkg::S_OUT: begin
                if (!lb_live) begin
                    n_lb = sbra_pkg::NO_SLOT;
                end
                if (!r_o_valid || m_axis_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    if (r_res_status == sbra_pkg::STATUS_OK) begin
                        n_o_addr = r_base + {16'd0, r_res_start};
                        n_o_size = r_res_len;
                        n_o_slot = 5'(r_res_slot);
                    end else begin
                        n_o_addr = '0;
                        n_o_size = '0;
                        n_o_slot = '0;
                    end
                    n_state = sbra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sbra_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sbra_pkg::REG_BUFFER_BASE: n_base  = i_cfg_data;
                sbra_pkg::REG_BUFFER_SIZE: n_bsize = i_cfg_data[15:0];
                default:                   n_base  = r_base;
            endcase
            n_used            = '0;
            n_free            = '0;
            n_lb              = sbra_pkg::NO_SLOT;
            tbl_ctl.clear_all = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sbra_pkg::S_IDLE;
            r_used    <= '0;
            r_free    <= '0;
            r_lb      <= sbra_pkg::NO_SLOT;
            r_base    <= '0;
            r_bsize   <= sbra_pkg::SIZE_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_free    <= n_free;
            r_lb      <= n_lb;
            r_base    <= n_base;
            r_bsize   <= n_bsize;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_req        <= n_req;
        r_addr       <= n_addr;
        r_size       <= n_size;
        r_avail      <= n_avail;
        r_off        <= n_off;
        r_ix         <= n_ix;
        r_p          <= n_p;
        r_mask       <= n_mask;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_len    <= n_res_len;
        r_res_slot   <= n_res_slot;
        r_o_status   <= n_o_status;
        r_o_addr     <= n_o_addr;
        r_o_size     <= n_o_size;
        r_o_slot     <= n_o_slot;
    end

    // last bumped slot is either none or a used slot between items
    a_lb_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbra_pkg::S_IDLE) |-> (lb_live || (r_lb == sbra_pkg::NO_SLOT)))
        else $error("last bumped slot names a free slot");

    // no used slot at or above the collapse search point
    a_find_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbra_pkg::S_FIND) |-> ((r_used >> r_p) == '0))
        else $error("used slot above collapse point");

    // a new result only comes out of the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == sbra_pkg::S_OUT))
        else $error("result loaded outside output state");

    // granted sizes stay aligned
    a_size_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_status == sbra_pkg::STATUS_OK)) |-> (r_o_size[2:0] == 3'd0))
        else $error("granted size not a multiple of eight");

endmodule

@@ tb/region_grant_checker.sv @@
// ----------------------------------------------------------------------------
// region_grant_checker
// Follows both stream channels and the register port of the slot bitmap
// region allocator, keeps its own copy of the slot table, the bump pointer
// and the buffer registers, predicts the grant for every accepted request
// and compares each returned grant with the oldest open prediction.
// ----------------------------------------------------------------------------
module region_grant_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // command[1:0], req_size[18:2], address[50:19]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // status[1:0], block_address[33:2],
                                        // block_size[49:34], slot[54:50]
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_checked,
    output int          o_pending,
    output logic [15:0] o_free_offset,
    output logic [31:0] o_bumped_addr,
    output logic [15:0] o_bumped_len
);

    localparam logic [31:0] GRAIN_MASK = 32'hFFFF_FFF8;
    localparam logic [31:0] GRAIN_LOW  = 32'h0000_0007;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
        logic [15:0] size;
        logic [4:0]  slot;
    } t_grant;

    logic [31:0] base_r;
    logic [15:0] size_r;
    logic [31:0] used_map;
    logic [15:0] start_tab [0:31];
    logic [15:0] len_tab [0:31];
    logic [15:0] free_ofs;
    logic [5:0]  last_bump;
    t_grant      grant_q [$];
    t_grant      seen_grant;
    t_grant      due_grant;
    int          n_errors;
    int          n_checked;

    task automatic clear_slots();
        used_map  = '0;
        free_ofs  = '0;
        last_bump = sbra_pkg::NO_SLOT;
        for (int i = 0; i < 32; i++) begin
            start_tab[i] = '0;
            len_tab[i]   = '0;
        end
    endtask

    task automatic grant_slot(input int idx, output t_grant g);
        g.status = sbra_pkg::STATUS_OK;
        g.addr   = base_r + {16'd0, start_tab[idx]};
        g.size   = len_tab[idx];
        g.slot   = idx[4:0];
    endtask

    task automatic predict_grant(input logic [55:0] item, output t_grant g);
        logic [1:0]         cmd;
        logic signed [16:0] req;
        logic [31:0]        addr;
        logic [31:0]        avail;
        logic [31:0]        want;
        logic [31:0]        ofs;
        logic [4:0]         lb;
        logic               hit;
        int                 p;
        cmd   = item[1:0];
        req   = item[18:2];
        addr  = item[50:19];
        g     = '0;
        hit   = 1'b0;
        lb    = last_bump[4:0];
        avail = (free_ofs < size_r) ? {16'd0, size_r} - {16'd0, free_ofs} : 32'd0;
        case (cmd)
            sbra_pkg::CMD_ALLOC: begin
                g.status = sbra_pkg::STATUS_NO_SPACE;
                if (req >= -1) begin
                    if (req == 0) begin
                        want = avail;
                    end else if (req == -1) begin
                        want = avail >> 1;
                    end else begin
                        want = {15'd0, req};
                    end
                    want = (want + GRAIN_LOW) & GRAIN_MASK;
                    for (int i = 0; i < 32; i++) begin
                        if (!hit && !used_map[i]) begin
                            if ((used_map >> i) == 0) begin
                                hit = 1'b1;
                                if (want <= avail) begin
                                    start_tab[i] = free_ofs;
                                    len_tab[i]   = want[15:0];
                                    free_ofs     = free_ofs + want[15:0];
                                    used_map[i]  = 1'b1;
                                    last_bump    = i[5:0];
                                    grant_slot(i, g);
                                end
                            end else if ({16'd0, len_tab[i]} == want) begin
                                hit         = 1'b1;
                                used_map[i] = 1'b1;
                                grant_slot(i, g);
                            end
                        end
                    end
                end
            end
            sbra_pkg::CMD_RELEASE: begin
                g.status = sbra_pkg::STATUS_NO_MATCH;
                ofs = addr - base_r;
                for (int i = 0; i < 32; i++) begin
                    if (!hit && used_map[i] && ofs >= {16'd0, start_tab[i]} &&
                        ofs < {16'd0, start_tab[i]} + {16'd0, len_tab[i]}) begin
                        hit = 1'b1;
                        grant_slot(i, g);
                        used_map[i] = 1'b0;
                        // top used slot gone: pull the bump pointer back
                        if ((used_map >> i) == 0) begin
                            p = 0;
                            for (int k = 0; k < i; k++) begin
                                if (used_map[k]) p = k + 1;
                            end
                            free_ofs = start_tab[p];
                            for (int k = p; k < 32; k++) begin
                                start_tab[k] = '0;
                                len_tab[k]   = '0;
                            end
                        end
                        if (last_bump >= 6'd32 || !used_map[last_bump[4:0]]) begin
                            last_bump = sbra_pkg::NO_SLOT;
                        end
                    end
                end
            end
            sbra_pkg::CMD_SHRINK: begin
                g.status = sbra_pkg::STATUS_NO_MATCH;
                if (last_bump < 6'd32 && used_map[lb] &&
                    base_r + {16'd0, start_tab[lb]} == addr) begin
                    want = (req < 0) ? 32'd0 : (({15'd0, req} + GRAIN_LOW) & GRAIN_MASK);
                    if (want > {16'd0, len_tab[lb]}) want = {16'd0, len_tab[lb]};
                    len_tab[lb] = want[15:0];
                    free_ofs    = start_tab[lb] + want[15:0];
                    grant_slot(lb, g);
                end
            end
            default: begin
                g.status = sbra_pkg::STATUS_NO_MATCH;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_r    = '0;
            size_r    = sbra_pkg::SIZE_RESET;
            n_errors  = 0;
            n_checked = 0;
            clear_slots();
            grant_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_grant.status = m_axis_tdata[1:0];
                seen_grant.addr   = m_axis_tdata[33:2];
                seen_grant.size   = m_axis_tdata[49:34];
                seen_grant.slot   = m_axis_tdata[54:50];
                if (grant_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected grant status %0d addr %h size %0d slot %0d",
                             $time, seen_grant.status, seen_grant.addr, seen_grant.size,
                             seen_grant.slot);
                end else begin
                    due_grant = grant_q.pop_front();
                    n_checked++;
                    if (seen_grant !== due_grant) begin
                        n_errors++;
                        $display({"%0t: grant mismatch: expected status %0d addr %h size %0d",
                                  " slot %0d, got status %0d addr %h size %0d slot %0d"},
                                 $time, due_grant.status, due_grant.addr, due_grant.size,
                                 due_grant.slot, seen_grant.status, seen_grant.addr,
                                 seen_grant.size, seen_grant.slot);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == sbra_pkg::REG_BUFFER_BASE) begin
                    base_r = i_cfg_data;
                end else begin
                    size_r = i_cfg_data[15:0];
                end
                clear_slots();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_grant(s_axis_tdata, due_grant);
                grant_q.push_back(due_grant);
            end
        end
        o_errors      <= n_errors;
        o_checked     <= n_checked;
        o_pending     <= grant_q.size();
        o_free_offset <= free_ofs;
        if (last_bump < 6'd32) begin
            o_bumped_addr <= base_r + {16'd0, start_tab[last_bump[4:0]]};
            o_bumped_len  <= len_tab[last_bump[4:0]];
        end else begin
            o_bumped_addr <= base_r;
            o_bumped_len  <= '0;
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, release and shrink requests into the slot bitmap region
// allocator over several buffer placements and sizes: a short hand-made
// sequence first, then random traffic built around live blocks, with bursty
// requests and a stalling result side. The grant checker beside the block
// predicts and compares every result; this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // command[1:0], req_size[18:2], address[50:19]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // status[1:0], block_address[33:2],
                                       // block_size[49:34], slot[54:50]
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [31:0] i_cfg_data    = '0;

    int          err_count;
    int          grants_checked;
    int          grants_open;
    logic [15:0] free_offset_hint;
    logic [31:0] bumped_addr_hint;
    logic [15:0] bumped_len_hint;

    int                 n_sent    = 0;
    int                 n_alloc   = 0;
    int                 n_release = 0;
    int                 n_shrink  = 0;
    int                 n_other   = 0;
    int                 n_configs = 1;
    int                 burst_left = 0;
    logic [31:0]        cur_base  = '0;
    logic [15:0]        cur_size  = sbra_pkg::SIZE_RESET;
    logic signed [16:0] recent_req [0:7];
    logic [15:0]        stall_pat = 16'hFFFF;
    int                 pat_age   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    slot_bitmap_region_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    region_grant_checker grant_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (err_count),
        .o_checked     (grants_checked),
        .o_pending     (grants_open),
        .o_free_offset (free_offset_hint),
        .o_bumped_addr (bumped_addr_hint),
        .o_bumped_len  (bumped_len_hint)
    );

    // result side stall pattern, reshuffled whenever pat_age wraps
    always @(posedge i_clk) begin
        if (pat_age == 47) begin
            pat_age   <= 0;
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
        end else begin
            pat_age   <= pat_age + 1;
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
        m_axis_tready <= stall_pat[0];
    end

    task automatic push_item(input logic [1:0] cmd, input logic signed [16:0] req,
                             input logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, addr, req, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
        if (cmd == sbra_pkg::CMD_ALLOC) n_alloc++;
        else if (cmd == sbra_pkg::CMD_RELEASE) n_release++;
        else if (cmd == sbra_pkg::CMD_SHRINK) n_shrink++;
        else n_other++;
    endtask

    // hold requests until every open grant is back
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (grants_checked != n_sent) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        wait_results_done();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_buffer(input logic [31:0] base, input logic [15:0] bytes);
        write_reg(sbra_pkg::REG_BUFFER_BASE, base);
        write_reg(sbra_pkg::REG_BUFFER_SIZE, {16'd0, bytes});
        cur_base = base;
        cur_size = bytes;
        n_configs++;
    endtask

    task automatic run_random(input int count);
        int                 pick;
        int                 sel;
        int                 span;
        logic [1:0]         cmd;
        logic signed [16:0] req;
        logic [31:0]        addr;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            req  = 17'($urandom);
            addr = $urandom;
            span = (cur_size < 16'd80) ? 8 : int'(cur_size / 16'd10);
            if (pick < 40) begin
                cmd = sbra_pkg::CMD_ALLOC;
                if (sel < 5) begin
                    req = 17'($urandom_range(1, span));
                    recent_req[$urandom_range(0, 7)] = req;
                end else if (sel < 7) begin
                    req = recent_req[$urandom_range(0, 7)];
                end else if (sel == 7) begin
                    req = 17'sd0;
                end else if (sel == 8) begin
                    req = -17'sd1;
                end
            end else if (pick < 75) begin
                cmd = sbra_pkg::CMD_RELEASE;
                if (sel != 0) addr = cur_base + $urandom_range(0, free_offset_hint + 8);
            end else if (pick < 92) begin
                cmd = sbra_pkg::CMD_SHRINK;
                if ($urandom_range(0, 3) != 0) begin
                    wait_results_done();
                    addr = bumped_addr_hint;
                end
                if (sel < 6) begin
                    req = 17'($urandom_range(0, bumped_len_hint + 16));
                end else if (sel < 8) begin
                    req = {1'b1, 16'($urandom)};
                end
            end else begin
                cmd = 2'($urandom);
            end
            push_item(cmd, req, addr);
        end
    endtask

    initial begin
        foreach (recent_req[i]) recent_req[i] = 17'sd8;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-made sequence on the reset buffer
        push_item(sbra_pkg::CMD_ALLOC, 17'sd1, 0);
        push_item(sbra_pkg::CMD_ALLOC, 17'sd8, 0);
        push_item(sbra_pkg::CMD_ALLOC, 17'sd100, 0);
        wait_results_done();
        push_item(sbra_pkg::CMD_SHRINK, 17'sd200, bumped_addr_hint);
        wait_results_done();
        push_item(sbra_pkg::CMD_SHRINK, 17'sd17, bumped_addr_hint);
        push_item(sbra_pkg::CMD_SHRINK, 17'sd8, bumped_addr_hint + 8);
        push_item(sbra_pkg::CMD_RELEASE, 17'sd0, 9);
        push_item(sbra_pkg::CMD_ALLOC, 17'sd8, 0);
        push_item(sbra_pkg::CMD_RELEASE, 17'sd0, 12);
        push_item(sbra_pkg::CMD_ALLOC, 17'sd16, 0);
        push_item(sbra_pkg::CMD_RELEASE, 17'sd0, 45);
        wait_results_done();
        push_item(sbra_pkg::CMD_SHRINK, 17'sd8, bumped_addr_hint);
        push_item(sbra_pkg::CMD_ALLOC, -17'sd1, 0);
        push_item(sbra_pkg::CMD_ALLOC, 17'sd0, 0);
        push_item(sbra_pkg::CMD_ALLOC, 17'sd0, 0);
        push_item(sbra_pkg::CMD_RELEASE, 17'sd0, 2000);
        push_item(sbra_pkg::CMD_ALLOC, 17'sh0FFFF, 0);
        push_item(sbra_pkg::CMD_ALLOC, -17'sd2, 0);
        push_item(sbra_pkg::CMD_ALLOC, 17'sh10000, 0);
        push_item(sbra_pkg::CMD_RELEASE, 17'sd0, 32'hFFFF_FFFF);
        push_item(CMD_UNKNOWN, 17'sh1FFFF, 32'hFFFF_FFFF);
        push_item(sbra_pkg::CMD_ALLOC, 17'sd40, 0);
        wait_results_done();
        push_item(sbra_pkg::CMD_SHRINK, -17'sd1, bumped_addr_hint);
        push_item(sbra_pkg::CMD_RELEASE, 17'sd0, 0);
        push_item(sbra_pkg::CMD_RELEASE, 17'sd0, 3);

        run_random(300);
        set_buffer(32'h1000_0000, 16'd512);
        run_random(220);
        set_buffer(32'hFFFF_FF80, 16'd384);
        run_random(220);
        set_buffer(32'h0000_0000, 16'd0);
        run_random(60);
        set_buffer(32'hFFFF_FFFF, 16'hFFFF);
        run_random(220);
        repeat (2) begin
            set_buffer($urandom, 16'($urandom_range(64, 1024)));
            run_random(150);
        end

        wait_results_done();
        repeat (80) @(posedge i_clk);
        $display("covered %0d requests: %0d allocate, %0d release, %0d shrink, %0d other",
                 n_sent, n_alloc, n_release, n_shrink, n_other);
        $display("over %0d buffer settings, %0d grants compared", n_configs, grants_checked);
        if (err_count == 0 && grants_open == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout waiting for the allocator");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sbra_pkg.sv
hdl/sbra_slot_table.sv
hdl/slot_bitmap_region_allocator.sv
tb/region_grant_checker.sv
tb/testbench.sv
